// ===== design/rrs_pkg.sv =====
package rrs_pkg;

  localparam int unsigned IDX_W = 10;
  localparam int unsigned VAL_W = 11;
  localparam int unsigned LEN_W = 11;

  localparam logic [LEN_W-1:0] LEN_RESET = 11'd1024;

  localparam logic FUNC_REVERSE = 1'b0;
  localparam logic FUNC_READ    = 1'b1;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  typedef enum logic [4:0] {
    ST_INIT = 5'b00001,
    ST_IDLE = 5'b00010,
    ST_SWL  = 5'b00100,
    ST_SWR  = 5'b01000,
    ST_FIN  = 5'b10000
  } state_e;

endpackage

// ===== design/rrs_in_if.sv =====
interface rrs_in_if import rrs_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             func;
  logic [IDX_W-1:0] left_index;
  logic [IDX_W-1:0] right_index;

  modport source (output valid, func, left_index, right_index, input ready);
  modport sink (input valid, func, left_index, right_index, output ready);
endinterface

// ===== design/rrs_out_if.sv =====
interface rrs_out_if import rrs_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [VAL_W-1:0] entry_value;
  logic             status;

  modport source (output valid, entry_value, status, input ready);
  modport sink (input valid, entry_value, status, output ready);
endinterface

// ===== design/rrs_mem.sv =====
module rrs_mem import rrs_pkg::*; #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [VAL_W-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_a_i,
  input  logic [AW-1:0]    raddr_b_i,
  output logic [VAL_W-1:0] rdata_a_o,
  output logic [VAL_W-1:0] rdata_b_o
);

  logic [VAL_W-1:0] mem_q [DEPTH];
  logic [VAL_W-1:0] rdata_a_q;
  logic [VAL_W-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_a_q <= mem_q[raddr_a_i];
      rdata_b_q <= mem_q[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

// ===== design/range_reverse_sequence.sv =====
// Flow: a read's entry is registered in the sequence memory, then loaded into the output
// register in ST_FIN, which waits while a held result is not yet taken.
// Throughput: one item at a time; each swapped pair is written in two states, SWL and
// SWR, because the sequence memory has a single write port.
// Reset: rst_ni clears control state, then an init pass over all MAX_LEN entries loads
// entry i with i+1; no input transaction is taken during it, configuration writes are taken.
module range_reverse_sequence import rrs_pkg::*; #(
  parameter int unsigned MAX_LEN = 1024
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [LEN_W-1:0] cfg_wdata_i,
  rrs_in_if.sink           in_i,
  rrs_out_if.source        out_o
);

  localparam int unsigned AW = $clog2(MAX_LEN);

  state_e           state_q, state_d;
  logic [AW-1:0]    init_cnt_q, init_cnt_d;
  logic [AW-1:0]    lq_q, lq_d;
  logic [AW-1:0]    rq_q, rq_d;
  logic             take_q, take_d;
  logic             status_q, status_d;
  logic [LEN_W-1:0] len_q;
  logic             out_valid_q, out_valid_d;
  logic [VAL_W-1:0] out_value_q, out_value_d;
  logic             out_status_q, out_status_d;

  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [VAL_W-1:0] mem_wdata;
  logic             mem_re;
  logic [AW-1:0]    mem_raddr_a;
  logic [AW-1:0]    mem_raddr_b;
  logic [VAL_W-1:0] mem_rdata_a;
  logic [VAL_W-1:0] mem_rdata_b;

  logic             accept;
  logic             left_ok;
  logic             right_ok;
  logic [AW-1:0]    next_l;
  logic [AW-1:0]    next_r;

  rrs_mem #(
    .DEPTH (MAX_LEN),
    .AW    (AW)
  ) u_mem (
    .clk_i     (clk_i),
    .we_i      (mem_we),
    .waddr_i   (mem_waddr),
    .wdata_i   (mem_wdata),
    .re_i      (mem_re),
    .raddr_a_i (mem_raddr_a),
    .raddr_b_i (mem_raddr_b),
    .rdata_a_o (mem_rdata_a),
    .rdata_b_o (mem_rdata_b)
  );

  assign in_i.ready = (state_q == ST_IDLE);
  assign accept     = in_i.valid && in_i.ready;

  assign left_ok  = (LEN_W'(in_i.left_index) < len_q) && (32'(in_i.left_index) < MAX_LEN);
  assign right_ok = (LEN_W'(in_i.right_index) < len_q) && (32'(in_i.right_index) < MAX_LEN);

  assign next_l = lq_q + AW'(1);
  assign next_r = rq_q - AW'(1);

  always_comb begin
    state_d      = state_q;
    init_cnt_d   = init_cnt_q;
    lq_d         = lq_q;
    rq_d         = rq_q;
    take_d       = take_q;
    status_d     = status_q;
    out_valid_d  = out_valid_q;
    out_value_d  = out_value_q;
    out_status_d = out_status_q;
    mem_we       = 1'b0;
    mem_waddr    = lq_q;
    mem_wdata    = mem_rdata_b;
    mem_re       = 1'b0;
    mem_raddr_a  = AW'(in_i.left_index);
    mem_raddr_b  = AW'(in_i.right_index);

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_INIT: begin
        mem_we     = 1'b1;
        mem_waddr  = init_cnt_q;
        mem_wdata  = VAL_W'({1'b0, init_cnt_q} + (AW + 1)'(1));
        init_cnt_d = init_cnt_q + AW'(1);
        if (init_cnt_q == AW'(MAX_LEN - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          take_d   = 1'b0;
          status_d = STATUS_OK;
          lq_d     = AW'(in_i.left_index);
          rq_d     = AW'(in_i.right_index);
          state_d  = ST_FIN;
          if (in_i.func == FUNC_READ) begin
            if (left_ok) begin
              mem_re = 1'b1;
              take_d = 1'b1;
            end else begin
              status_d = STATUS_ERR;
            end
          end else if ((in_i.left_index > in_i.right_index) || !right_ok) begin
            status_d = STATUS_ERR;
          end else if (in_i.left_index != in_i.right_index) begin
            mem_re  = 1'b1;
            state_d = ST_SWL;
          end
        end
      end
      ST_SWL: begin
        mem_we    = 1'b1;
        mem_waddr = lq_q;
        mem_wdata = mem_rdata_b;
        state_d   = ST_SWR;
      end
      ST_SWR: begin
        mem_we      = 1'b1;
        mem_waddr   = rq_q;
        mem_wdata   = mem_rdata_a;
        mem_raddr_a = next_l;
        mem_raddr_b = next_r;
        if (next_l < next_r) begin
          mem_re  = 1'b1;
          lq_d    = next_l;
          rq_d    = next_r;
          state_d = ST_SWL;
        end else begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d  = 1'b1;
          out_value_d  = take_q ? mem_rdata_a : '0;
          out_status_d = status_q;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      init_cnt_q  <= '0;
      out_valid_q <= 1'b0;
      len_q       <= LEN_RESET;
    end else begin
      state_q     <= state_d;
      init_cnt_q  <= init_cnt_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        len_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    lq_q         <= lq_d;
    rq_q         <= rq_d;
    take_q       <= take_d;
    status_q     <= status_d;
    out_value_q  <= out_value_d;
    out_status_q <= out_status_d;
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.entry_value = out_value_q;
  assign out_o.status      = out_status_q;

endmodule

// ===== design/rrs_checker.sv =====
module rrs_checker import rrs_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_i,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input logic [VAL_W-1:0] out_entry_value_i,
  input logic             out_status_i
);

  // The block works on one item at a time, so it is busy right after taking one.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !in_ready_i)
    else $error("input ready high in the cycle after a transaction");

  // A refused item never carries an entry value.
  a_err_zero_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && (out_status_i == STATUS_ERR)) |-> (out_entry_value_i == '0))
    else $error("refused item with nonzero entry value");

  // No result appears in the cycle right after an input transaction.
  a_no_early_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((in_valid_i && in_ready_i) && !out_valid_i) |=> !out_valid_i)
    else $error("result appeared one cycle after its input transaction");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      (out_valid_i && $stable(out_entry_value_i) && $stable(out_status_i)))
    else $error("stalled result changed or dropped");

endmodule

bind range_reverse_sequence rrs_checker u_rrs_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_i.valid),
  .in_ready_i        (in_i.ready),
  .out_valid_i       (out_o.valid),
  .out_ready_i       (out_o.ready),
  .out_entry_value_i (out_o.entry_value),
  .out_status_i      (out_o.status)
);

// ===== dv/rrs_reversal_checker.sv =====
`timescale 1ns / 1ps

module rrs_reversal_checker import rrs_pkg::*; #(
  parameter int unsigned MAX_LEN = 1024
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [LEN_W-1:0] cfg_wdata_i,
  rrs_in_if                in_i,
  rrs_out_if               out_i,
  output int unsigned      mismatches_o,
  output int unsigned      pending_o
);

  typedef struct packed {
    logic [VAL_W-1:0] entry_value;
    logic             status;
  } outcome_t;

  logic [VAL_W-1:0] mirror_seq [MAX_LEN];
  logic [LEN_W-1:0] length_q;
  outcome_t         expected_q [$];
  outcome_t         oldest;
  int unsigned      mismatches;

  assign mismatches_o = mismatches;
  assign pending_o    = expected_q.size();

  function automatic int unsigned usable_length();
    if (length_q > MAX_LEN) return MAX_LEN;
    return 32'(length_q);
  endfunction

  // Applies one transaction to the mirrored sequence and returns its outcome.
  function automatic outcome_t apply_item(logic func, logic [IDX_W-1:0] left,
                                          logic [IDX_W-1:0] right);
    outcome_t         res;
    int unsigned      n;
    int unsigned      lo;
    int unsigned      hi;
    logic [VAL_W-1:0] tmp;
    res.entry_value = '0;
    res.status      = STATUS_OK;
    n  = usable_length();
    lo = 32'(left);
    hi = 32'(right);
    if (func == FUNC_READ) begin
      if (lo >= n) res.status = STATUS_ERR;
      else res.entry_value = mirror_seq[lo];
      return res;
    end
    if (lo > hi || hi >= n) begin
      res.status = STATUS_ERR;
      return res;
    end
    while (lo < hi) begin
      tmp            = mirror_seq[lo];
      mirror_seq[lo] = mirror_seq[hi];
      mirror_seq[hi] = tmp;
      lo++;
      hi--;
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_LEN; i++) mirror_seq[i] = VAL_W'(i + 1);
      length_q <= LEN_RESET;
      expected_q.delete();
      mismatches = 0;
    end else begin
      if (out_i.valid && out_i.ready) begin
        if (expected_q.size() == 0) begin
          $error("unexpected result: entry_value=%0d status=%0d",
                 out_i.entry_value, out_i.status);
          mismatches++;
        end else begin
          oldest = expected_q.pop_front();
          if (out_i.entry_value !== oldest.entry_value) begin
            $error("entry_value mismatch: expected %0d, actual %0d",
                   oldest.entry_value, out_i.entry_value);
            mismatches++;
          end
          if (out_i.status !== oldest.status) begin
            $error("status mismatch: expected %0d, actual %0d",
                   oldest.status, out_i.status);
            mismatches++;
          end
        end
      end
      if (in_i.valid && in_i.ready) begin
        expected_q.insert(expected_q.size(),
                          apply_item(in_i.func, in_i.left_index, in_i.right_index));
      end
      if (cfg_we_i) length_q <= cfg_wdata_i;
    end
  end

endmodule

// ===== dv/tb_range_reverse_sequence.sv =====
`timescale 1ns / 1ps

module tb_range_reverse_sequence;
  import rrs_pkg::*;

  localparam int unsigned MAX_LEN        = 1024;
  localparam int unsigned WATCHDOG_LIMIT = 12000;
  localparam int unsigned TAIL_CYCLES    = 50;
  localparam int unsigned RANDOM_ITEMS   = 450;
  localparam int unsigned NUM_PHASES     = 8;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [LEN_W-1:0] cfg_wdata_i;
  logic [LEN_W-1:0] cur_len;
  logic [LEN_W-1:0] phase_len [NUM_PHASES];
  int unsigned      mismatches;
  int unsigned      pending;
  int unsigned      idle_cycles = 0;
  bit               calm = 1'b0;

  rrs_in_if  in_ch ();
  rrs_out_if out_ch ();

  range_reverse_sequence #(.MAX_LEN(MAX_LEN)) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_ch),
    .out_o       (out_ch)
  );

  rrs_reversal_checker #(.MAX_LEN(MAX_LEN)) checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_i         (in_ch),
    .out_i        (out_ch),
    .mismatches_o (mismatches),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_range_reverse_sequence: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int unsigned hold;
    int unsigned stall;
    out_ch.ready = 1'b0;
    @(posedge clk_i);
    forever begin
      hold = $urandom_range(1, 24);
      out_ch.ready <= 1'b1;
      repeat (hold) @(posedge clk_i);
      stall = pick_gap();
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
    end
  end

  task automatic send_item(input logic func, input logic [IDX_W-1:0] left,
                           input logic [IDX_W-1:0] right);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid       <= 1'b1;
    in_ch.func        <= func;
    in_ch.left_index  <= left;
    in_ch.right_index <= right;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic set_length(input logic [LEN_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    cur_len = value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Mostly in-range transactions with short spans, some with spans up to the full
  // length, and a share of fully random ones, which may or may not be refused.
  task automatic random_item();
    int unsigned n;
    int unsigned lo;
    int unsigned hi;
    int unsigned span;
    int unsigned r;
    logic        func;
    n = (cur_len > MAX_LEN) ? MAX_LEN : cur_len;
    func = ($urandom_range(0, 99) < 30) ? FUNC_READ : FUNC_REVERSE;
    if (n == 0 || $urandom_range(0, 99) < 15) begin
      send_item(func, IDX_W'($urandom), IDX_W'($urandom));
    end else begin
      lo = $urandom_range(0, n - 1);
      r  = $urandom_range(0, 99);
      if (r < 80) span = $urandom_range(0, 15);
      else if (r < 95) span = $urandom_range(0, 100);
      else span = $urandom_range(0, n - 1);
      hi = lo + span;
      if (hi > n - 1) hi = n - 1;
      if (func == FUNC_READ) send_item(func, IDX_W'(lo), IDX_W'($urandom));
      else send_item(func, IDX_W'(lo), IDX_W'(hi));
    end
  endtask

  initial begin
    rst_ni            = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_wdata_i       = '0;
    cur_len           = LEN_RESET;
    in_ch.valid       = 1'b0;
    in_ch.func        = FUNC_REVERSE;
    in_ch.left_index  = '0;
    in_ch.right_index = '0;
    phase_len = '{11'd1024, 11'd2, 11'd37, 11'd1024, 11'd300, 11'd2047, 11'd1,
                  LEN_W'($urandom_range(3, 1024))};
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_length(11'd1024);
    send_item(FUNC_READ, 10'd0, 10'd0);
    send_item(FUNC_READ, 10'd1023, 10'd1023);
    send_item(FUNC_REVERSE, 10'd0, 10'd1023);
    send_item(FUNC_READ, 10'd0, 10'd0);
    send_item(FUNC_READ, 10'd1023, 10'd0);
    send_item(FUNC_REVERSE, 10'd5, 10'd5);
    send_item(FUNC_REVERSE, 10'd10, 10'd3);
    send_item(FUNC_READ, 10'd500, 10'd0);
    send_item(FUNC_REVERSE, 10'd0, 10'd1);
    send_item(FUNC_READ, 10'd0, 10'd1023);
    wait_drained();

    set_length(11'd2047);
    send_item(FUNC_READ, 10'd1023, 10'd0);
    send_item(FUNC_REVERSE, 10'd1000, 10'd1023);
    wait_drained();

    set_length(11'd0);
    send_item(FUNC_READ, 10'd0, 10'd0);
    send_item(FUNC_REVERSE, 10'd0, 10'd0);
    wait_drained();

    set_length(11'd1);
    send_item(FUNC_READ, 10'd0, 10'd0);
    send_item(FUNC_READ, 10'd1, 10'd0);
    send_item(FUNC_REVERSE, 10'd0, 10'd0);
    send_item(FUNC_REVERSE, 10'd0, 10'd1);
    wait_drained();

    set_length(11'd512);
    send_item(FUNC_READ, 10'd511, 10'd0);
    send_item(FUNC_READ, 10'd512, 10'd0);
    send_item(FUNC_REVERSE, 10'd500, 10'd511);
    send_item(FUNC_REVERSE, 10'd511, 10'd512);
    wait_drained();

    set_length(11'd1024);
    send_item(FUNC_READ, 10'd700, 10'd0);
    send_item(FUNC_READ, 10'd1023, 10'd0);
    wait_drained();

    for (int p = 0; p < NUM_PHASES; p++) begin
      calm = ($urandom_range(0, 3) == 0);
      set_length(phase_len[p]);
      for (int i = 0; i < RANDOM_ITEMS / NUM_PHASES; i++) begin
        random_item();
        if ($urandom_range(0, 99) < 3) wait_drained();
      end
      wait_drained();
    end
    calm = 1'b0;

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb_range_reverse_sequence: PASS");
    end else begin
      $display("tb_range_reverse_sequence: FAIL");
    end
    $finish;
  end

endmodule
